// ----- sv/rnh_pkg.sv -----
// Package for the ray nearest-hit caster: item and result structs, command
// codes, fixed-point constants and the CORDIC arctangent table.
// Used by every module of the block but rnh_queue; depends on nothing.
package rnh_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] CFG_VIEW_RANGE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OBSTACLE_RADIUS = 2'd1;
  localparam logic [23:0] VIEW_RANGE_RESET = 24'd38400;
  localparam logic [15:0] RADIUS_RESET     = 16'd4096;

  // Input mode codes
  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_CIRCLE  = 2'd1;
  localparam logic [1:0] MODE_SEGMENT = 2'd2;

  // Fixed-point constants
  localparam logic signed [33:0] GAIN_Q30      = 34'sd652032875;
  localparam logic signed [33:0] ROUND_Q30     = 34'sd8192;
  localparam logic signed [20:0] PI_Q16        = 21'sd205887;
  localparam logic signed [20:0] HALF_PI_Q16   = 21'sd102944;
  localparam logic signed [20:0] TWO_PI_Q16    = 21'sd411775;
  localparam logic signed [33:0] UNIT_Q16      = 34'sd65536;
  localparam logic signed [58:0] DENOM_MIN_Q32 = 59'sd4294967;
  localparam logic [16:0]        RATIO_MAX     = 17'd65536;
  localparam int                 ATAN_LEN      = 24;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_CIRCLE,
    CMD_SEGMENT,
    CMD_NONE
  } cmd_t;

  typedef enum logic {
    ITER_DIV,
    ITER_SQRT
  } iter_op_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [15:0] angle;
    logic [2:0]         ray_slot;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [16:0] distance_ratio;
    logic [2:0]  slot_out;
  } out_item_t;

  // Classified request handed from front to back
  typedef struct packed {
    cmd_t               cmd;
    logic               last;
    logic [2:0]         slot;
    logic               flip;
    logic signed [17:0] z0;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
  } work_t;

  // Request to the shared divide / square-root unit
  typedef struct packed {
    logic        start;
    iter_op_t    op;
    logic [63:0] dividend;
    logic [28:0] divisor;
    logic [31:0] radicand;
  } iter_req_t;

  // atan(2^-i) in Q.16
  function automatic logic [15:0] atan_q16(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:    v = 16'd51472;
      5'd1:    v = 16'd30385;
      5'd2:    v = 16'd16055;
      5'd3:    v = 16'd8150;
      5'd4:    v = 16'd4091;
      5'd5:    v = 16'd2047;
      5'd6:    v = 16'd1024;
      5'd7:    v = 16'd512;
      5'd8:    v = 16'd256;
      5'd9:    v = 16'd128;
      5'd10:   v = 16'd64;
      5'd11:   v = 16'd32;
      5'd12:   v = 16'd16;
      5'd13:   v = 16'd8;
      5'd14:   v = 16'd4;
      5'd15:   v = 16'd2;
      5'd16:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/rnh_queue.sv -----
// Small first-in first-out queue of flops with full and empty flags.
// Generic; used between front and back and on the result side.
module rnh_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/rnh_front.sv -----
// Front end: classifies an incoming item into a command and folds the ray
// angle into the CORDIC range. Depends on rnh_pkg.
module rnh_front (
  input  rnh_pkg::in_item_t item,
  output rnh_pkg::work_t    work
);
  import rnh_pkg::*;

  logic signed [20:0] a0;
  logic signed [20:0] a1;
  logic signed [20:0] a2;
  logic               flip;

  // Angle to Q.16, one fold by 2*pi, then by pi into [-pi/2, pi/2]
  always_comb begin
    a0   = {item.angle[15], item.angle, 4'b0000};
    flip = 1'b0;
    if (a0 > PI_Q16) begin
      a1 = a0 - TWO_PI_Q16;
    end else if (a0 < -PI_Q16) begin
      a1 = a0 + TWO_PI_Q16;
    end else begin
      a1 = a0;
    end
    if (a1 > HALF_PI_Q16) begin
      a2   = a1 - PI_Q16;
      flip = 1'b1;
    end else if (a1 < -HALF_PI_Q16) begin
      a2   = a1 + PI_Q16;
      flip = 1'b1;
    end else begin
      a2 = a1;
    end
  end

  // Command decode and operand selection
  always_comb begin
    unique case (item.mode)
      MODE_START:   work.cmd = CMD_START;
      MODE_CIRCLE:  work.cmd = CMD_CIRCLE;
      MODE_SEGMENT: work.cmd = CMD_SEGMENT;
      default:      work.cmd = CMD_NONE;
    endcase
    work.last = item.last;
    work.slot = item.ray_slot;
    work.flip = flip;
    work.z0   = a2[17:0];
    work.ax   = (item.mode == MODE_START) ? item.origin_x : item.point_x;
    work.ay   = (item.mode == MODE_START) ? item.origin_y : item.point_y;
    work.bx   = item.end_x;
    work.by   = item.end_y;
  end

endmodule

// ----- sv/rnh_iter.sv -----
// Shared iterative unit: restoring division (one quotient bit a cycle) and
// digit-by-digit integer square root (one result bit a cycle).
// Depends on rnh_pkg.
module rnh_iter (
  input  logic               clk,
  input  logic               rst,
  input  rnh_pkg::iter_req_t req,
  output logic               done,
  output logic [63:0]        result
);
  import rnh_pkg::*;

  localparam logic [6:0] DIV_LAST  = 7'd63;
  localparam logic [6:0] SQRT_LAST = 7'd15;

  logic        active;
  iter_op_t    op_r;
  logic [6:0]  cnt;
  logic [63:0] quo;
  logic [28:0] rem;
  logic [28:0] div_r;
  logic [31:0] sv;
  logic [31:0] sroot;
  logic [31:0] sbit;
  logic [29:0] rem_sh;
  logic [29:0] diff;
  logic        ge;
  logic [32:0] ssum;
  logic        sge;
  logic        last_step;

  assign rem_sh    = {rem, quo[63]};
  assign ge        = (rem_sh >= {1'b0, div_r});
  assign diff      = rem_sh - {1'b0, div_r};
  assign ssum      = {1'b0, sroot} + {1'b0, sbit};
  assign sge       = ({1'b0, sv} >= ssum);
  assign last_step = (op_r == ITER_DIV) ? (cnt == DIV_LAST) : (cnt == SQRT_LAST);
  assign result    = (op_r == ITER_DIV) ? quo : {32'b0, sroot};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
      op_r   <= ITER_DIV;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        op_r   <= req.op;
        cnt    <= '0;
        quo    <= req.dividend;
        rem    <= '0;
        div_r  <= req.divisor;
        sv     <= req.radicand;
        sroot  <= '0;
        sbit   <= 32'h4000_0000;
      end else if (active) begin
        if (op_r == ITER_DIV) begin
          quo <= {quo[62:0], ge};
          rem <= ge ? diff[28:0] : rem_sh[28:0];
        end else begin
          if (sge) begin
            sv    <= sv - ssum[31:0];
            sroot <= (sroot >> 1) + sbit;
          end else begin
            sroot <= sroot >> 1;
          end
          sbit <= sbit >> 2;
        end
        cnt <= cnt + 1'b1;
        if (last_step) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- sv/rnh_back.sv -----
// Back end: sequencer holding the ray state; runs CORDIC, the dot and cross
// products on one shared multiplier, and the hit tests. Depends on rnh_pkg
// and rnh_iter.
module rnh_back #(
  parameter int CORDIC_STEPS = 16,
  parameter int RAY_SLOTS    = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               work_empty,
  output logic               work_pop,
  input  rnh_pkg::work_t     work,
  input  logic [23:0]        view_range,
  input  logic [15:0]        obstacle_radius,
  input  logic               res_full,
  output logic               res_push,
  output rnh_pkg::out_item_t res
);
  import rnh_pkg::*;

  localparam int         STEPS     = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);

  typedef enum logic [18:0] {
    ST_IDLE      = 19'h00001,
    ST_CORDIC    = 19'h00002,
    ST_CORD_END  = 19'h00004,
    ST_PROD      = 19'h00008,
    ST_ACC       = 19'h00010,
    ST_CIRC_CHK  = 19'h00020,
    ST_CIRC_SQ   = 19'h00040,
    ST_CIRC_RR   = 19'h00080,
    ST_CIRC_RAD  = 19'h00100,
    ST_CIRC_ROOT = 19'h00200,
    ST_SEG_CHK   = 19'h00400,
    ST_SEG_REJ   = 19'h00800,
    ST_SEG_NORM  = 19'h01000,
    ST_SEG_MUL   = 19'h02000,
    ST_SEG_ACC   = 19'h04000,
    ST_SEG_QUO   = 19'h08000,
    ST_EMIT      = 19'h10000,
    ST_RATIO     = 19'h20000,
    ST_PUSH      = 19'h40000
  } state_t;

  state_t state;

  // Ray state
  logic signed [31:0] sx;
  logic signed [31:0] sy;
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  logic [23:0]        nearest;
  logic [2:0]         slot_held;

  // Per-request working registers
  logic               last_r;
  logic               is_seg;
  logic [2:0]         k;
  logic signed [33:0] cx;
  logic signed [33:0] cy;
  logic signed [19:0] cz;
  logic [4:0]         cnt;
  logic               flip_r;
  logic signed [32:0] oa_x;
  logic signed [32:0] oa_y;
  logic signed [32:0] ob_x;
  logic signed [32:0] ob_y;
  logic signed [51:0] along_a;
  logic signed [51:0] across_a;
  logic signed [51:0] along_b;
  logic signed [51:0] across_b;
  logic [23:0]        p8_r;
  logic [15:0]        e8_r;
  logic [31:0]        esq_r;
  logic [51:0]        wa;
  logic [51:0]        wb;
  logic [28:0]        den_r;
  logic signed [65:0] num;
  logic [16:0]        ratio_r;
  logic signed [58:0] prod;

  // Combinational helpers
  logic signed [24:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [32:0] sel_ox;
  logic signed [32:0] sel_oy;
  logic signed [51:0] prod52;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [19:0] at;
  logic signed [33:0] rx;
  logic signed [33:0] ry;
  logic signed [17:0] ux;
  logic signed [17:0] uy;
  logic [35:0]        p8;
  logic [51:0]        abs_a;
  logic [51:0]        abs_b;
  logic [35:0]        e8;
  logic signed [24:0] act;
  logic signed [52:0] dd;
  logic [52:0]        md;
  logic               sign_ok;
  logic signed [35:0] al8;
  logic [51:0]        wsel;
  logic signed [65:0] term;
  logic signed [65:0] num_next;
  logic [28:0]        den_sum;
  iter_req_t          req;
  logic               iter_done;
  logic [63:0]        iter_res;

  function automatic logic signed [17:0] clamp_unit(input logic signed [33:0] v);
    logic signed [33:0] c;
    if (v > UNIT_Q16) begin
      c = UNIT_Q16;
    end else if (v < -UNIT_Q16) begin
      c = -UNIT_Q16;
    end else begin
      c = v;
    end
    return c[17:0];
  endfunction

  rnh_iter u_iter (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .done   (iter_done),
    .result (iter_res)
  );

  // Datapath helpers
  always_comb begin
    sel_ox   = k[2] ? ob_x : oa_x;
    sel_oy   = k[2] ? ob_y : oa_y;
    prod52   = prod[51:0];
    xs       = cx >>> cnt;
    ys       = cy >>> cnt;
    at       = {4'b0000, atan_q16(cnt)};
    rx       = (cx + ROUND_Q30) >>> 14;
    ry       = (cy + ROUND_Q30) >>> 14;
    ux       = clamp_unit(rx);
    uy       = clamp_unit(ry);
    p8       = along_a[51:16];
    abs_a    = across_a[51] ? 52'(-across_a) : across_a;
    abs_b    = across_b[51] ? 52'(-across_b) : across_b;
    e8       = abs_a[51:16];
    act      = $signed({1'b0, p8_r}) - $signed({9'b0, iter_res[15:0]});
    dd       = 53'(across_b) - 53'(across_a);
    md       = dd[52] ? 53'(-dd) : dd;
    sign_ok  = (!across_a[51] && (across_b[51] || across_b == '0)) ||
               ((across_a[51] || across_a == '0) && !across_b[51]);
    al8      = k[1] ? along_b[51:16] : along_a[51:16];
    wsel     = k[1] ? wa : wb;
    term     = k[0] ? (66'(prod) <<< 24) : 66'(prod);
    num_next = (k[1:0] == 2'd0) ? term : num + term;
    den_sum  = {1'b0, wa[27:0]} + {1'b0, wb[27:0]};
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_PROD: begin
        unique case (k[1:0])
          2'd0:    begin mul_a = 25'(dx); mul_b = 34'(sel_ox); end
          2'd1:    begin mul_a = 25'(dy); mul_b = 34'(sel_oy); end
          2'd2:    begin mul_a = 25'(dx); mul_b = 34'(sel_oy); end
          default: begin mul_a = 25'(dy); mul_b = 34'(sel_ox); end
        endcase
      end
      ST_CIRC_SQ: begin
        mul_a = {9'b0, e8_r};
        mul_b = {18'b0, e8_r};
      end
      ST_CIRC_RR: begin
        mul_a = {9'b0, obstacle_radius};
        mul_b = {18'b0, obstacle_radius};
      end
      ST_SEG_CHK: begin
        mul_a = {2'b00, md[22:0]};
        mul_b = {10'b0, view_range};
      end
      ST_SEG_MUL: begin
        mul_a = k[0] ? 25'($signed(al8[35:24])) : $signed({1'b0, al8[23:0]});
        mul_b = {6'b0, wsel[27:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Requests to the divide / square-root unit
  always_comb begin
    req.start    = 1'b0;
    req.op       = ITER_DIV;
    req.dividend = '0;
    req.divisor  = '0;
    req.radicand = prod[31:0] - esq_r;
    if (state == ST_CIRC_RAD) begin
      req.start = 1'b1;
      req.op    = ITER_SQRT;
    end else if (state == ST_SEG_ACC && k[1:0] == 2'd3 && !num_next[65]) begin
      req.start    = 1'b1;
      req.dividend = num_next[63:0];
      req.divisor  = den_r;
    end else if (state == ST_EMIT && last_r && 32'(slot_held) < RAY_SLOTS &&
                 view_range != '0) begin
      req.start    = 1'b1;
      req.dividend = {24'b0, nearest, 16'b0};
      req.divisor  = {5'b0, view_range};
    end
  end

  assign work_pop           = (state == ST_IDLE) && !work_empty;
  assign res_push           = (state == ST_PUSH) && !res_full;
  assign res.distance_ratio = ratio_r;
  assign res.slot_out       = slot_held;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sx        <= '0;
      sy        <= '0;
      dx        <= '0;
      dy        <= '0;
      nearest   <= '0;
      slot_held <= '0;
      k         <= '0;
      cnt       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!work_empty) begin
            last_r <= work.last;
            k      <= '0;
            oa_x   <= 33'(work.ax) - 33'(sx);
            oa_y   <= 33'(work.ay) - 33'(sy);
            ob_x   <= 33'(work.bx) - 33'(sx);
            ob_y   <= 33'(work.by) - 33'(sy);
            unique case (work.cmd)
              CMD_START: begin
                sx        <= work.ax;
                sy        <= work.ay;
                slot_held <= work.slot;
                nearest   <= view_range;
                cx        <= GAIN_Q30;
                cy        <= '0;
                cz        <= 20'(work.z0);
                flip_r    <= work.flip;
                cnt       <= '0;
                state     <= ST_CORDIC;
              end
              CMD_CIRCLE: begin
                is_seg <= 1'b0;
                state  <= ST_PROD;
              end
              CMD_SEGMENT: begin
                is_seg <= 1'b1;
                state  <= ST_PROD;
              end
              default: state <= ST_EMIT;
            endcase
          end
        end

        // One CORDIC rotation a cycle
        ST_CORDIC: begin
          if (!cz[19]) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - at;
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + at;
          end
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            state <= ST_CORD_END;
          end
        end

        ST_CORD_END: begin
          dx    <= flip_r ? -ux : ux;
          dy    <= flip_r ? -uy : uy;
          state <= ST_EMIT;
        end

        ST_PROD: state <= ST_ACC;

        // Collect along and across terms of each point
        ST_ACC: begin
          unique case (k[1:0])
            2'd0: begin
              if (k[2]) along_b <= prod52; else along_a <= prod52;
            end
            2'd1: begin
              if (k[2]) along_b <= along_b + prod52; else along_a <= along_a + prod52;
            end
            2'd2: begin
              if (k[2]) across_b <= prod52; else across_a <= prod52;
            end
            default: begin
              if (k[2]) across_b <= across_b - prod52; else across_a <= across_a - prod52;
            end
          endcase
          if (is_seg && k == 3'd7) begin
            state <= ST_SEG_CHK;
          end else if (!is_seg && k == 3'd3) begin
            state <= ST_CIRC_CHK;
          end else begin
            k     <= k + 1'b1;
            state <= ST_PROD;
          end
        end

        // Circle: in front, nearer than best, close enough to the ray
        ST_CIRC_CHK: begin
          p8_r <= p8[23:0];
          e8_r <= e8[15:0];
          if (along_a[51] || along_a == '0 || p8 >= {12'b0, nearest} ||
              e8 > {20'b0, obstacle_radius}) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_CIRC_SQ;
          end
        end

        ST_CIRC_SQ: state <= ST_CIRC_RR;

        ST_CIRC_RR: begin
          esq_r <= prod[31:0];
          state <= ST_CIRC_RAD;
        end

        ST_CIRC_RAD: state <= ST_CIRC_ROOT;

        ST_CIRC_ROOT: begin
          if (iter_done) begin
            if (!act[24] && act != '0 && act[23:0] < nearest) begin
              nearest <= act[23:0];
            end
            state <= ST_EMIT;
          end
        end

        // Segment: reject zero view range, near-parallel or not crossing the ray line
        ST_SEG_CHK: begin
          wa <= abs_a;
          wb <= abs_b;
          if (view_range == '0 || !sign_ok) begin
            state <= ST_EMIT;
          end else if (|md[52:23]) begin
            state <= ST_SEG_NORM;
          end else begin
            state <= ST_SEG_REJ;
          end
        end

        ST_SEG_REJ: begin
          state <= (prod <= DENOM_MIN_Q32) ? ST_EMIT : ST_SEG_NORM;
        end

        // Scale the weights down together one bit a cycle
        ST_SEG_NORM: begin
          if (|(wa[51:28] | wb[51:28])) begin
            wa <= wa >> 1;
            wb <= wb >> 1;
          end else begin
            den_r <= den_sum;
            k     <= '0;
            state <= (den_sum == '0) ? ST_EMIT : ST_SEG_MUL;
          end
        end

        ST_SEG_MUL: state <= ST_SEG_ACC;

        ST_SEG_ACC: begin
          num <= num_next;
          if (k[1:0] == 2'd3) begin
            state <= num_next[65] ? ST_EMIT : ST_SEG_QUO;
          end else begin
            k     <= k + 1'b1;
            state <= ST_SEG_MUL;
          end
        end

        ST_SEG_QUO: begin
          if (iter_done) begin
            if (iter_res <= {40'b0, view_range} && iter_res < {40'b0, nearest}) begin
              nearest <= iter_res[23:0];
            end
            state <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (!last_r || 32'(slot_held) >= RAY_SLOTS) begin
            state <= ST_IDLE;
          end else if (view_range == '0) begin
            ratio_r <= RATIO_MAX;
            state   <= ST_PUSH;
          end else begin
            state <= ST_RATIO;
          end
        end

        ST_RATIO: begin
          if (iter_done) begin
            ratio_r <= (iter_res > {47'b0, RATIO_MAX}) ? RATIO_MAX : iter_res[16:0];
            state   <= ST_PUSH;
          end
        end

        ST_PUSH: begin
          if (!res_full) begin
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/ray_nearest_hit_caster.sv -----
// Ray nearest-hit caster. One item is worked at a time by the back end. A
// start runs CORDIC; a circle, the products and maybe a square root; a
// segment, the products, weight scaling and maybe a divide; an item with
// last may add the ratio divide. The shared one-bit-a-cycle divider sets
// the worst case. Synchronous reset clears the queues, the ray state and
// the registers to their defaults; no clearing pass.
module ray_nearest_hit_caster #(
  parameter int CORDIC_STEPS = 16,
  parameter int RAY_SLOTS    = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  rnh_pkg::in_item_t                    item,
  output logic                                 empty,
  input  logic                                 pop,
  output rnh_pkg::out_item_t                   result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rnh_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [rnh_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import rnh_pkg::*;

  localparam int WORK_W = $bits(work_t);
  localparam int OUT_W  = $bits(out_item_t);

  logic [23:0]       view_range;
  logic [15:0]       obstacle_radius;
  work_t             work_in;
  logic [WORK_W-1:0] work_bits;
  logic              work_empty;
  logic              work_pop;
  out_item_t         res;
  logic              res_push;
  logic              res_full;
  logic [OUT_W-1:0]  res_bits;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_range      <= VIEW_RANGE_RESET;
      obstacle_radius <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VIEW_RANGE:      view_range      <= cfg_data;
        CFG_OBSTACLE_RADIUS: obstacle_radius <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  rnh_front u_front (
    .item (item),
    .work (work_in)
  );

  // Request queue between front and back
  rnh_queue #(
    .WIDTH (WORK_W),
    .DEPTH (2)
  ) u_work_q (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (work_in),
    .full    (full),
    .pop     (work_pop),
    .rd_data (work_bits),
    .empty   (work_empty)
  );

  rnh_back #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .RAY_SLOTS    (RAY_SLOTS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .work_empty      (work_empty),
    .work_pop        (work_pop),
    .work            (work_t'(work_bits)),
    .view_range      (view_range),
    .obstacle_radius (obstacle_radius),
    .res_full        (res_full),
    .res_push        (res_push),
    .res             (res)
  );

  // Result queue
  rnh_queue #(
    .WIDTH (OUT_W),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_bits),
    .empty   (empty)
  );

  assign result = out_item_t'(res_bits);

endmodule

// ----- tb/sv/ray_nearest_hit_caster_test.sv -----
// Self-checking testbench for ray_nearest_hit_caster: directed cases, then random ray
// sequences with bursty idling on the request and result queues, checked against an
// in-bench hit predictor. Depends on rnh_pkg and the ray_nearest_hit_caster RTL only.
module ray_nearest_hit_caster_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rnh_pkg::*;

  localparam int  STEPS       = 16;
  localparam int  SLOTS       = 8;
  localparam int  SETTLE      = 400;
  localparam longint LIMIT    = 1000000;

  // Hit predictor: ray state, registers and the queue of expected results
  class hit_scoreboard;
    longint view_range, radius;
    longint org_x, org_y, dir_x, dir_y, nearest, slot;
    out_item_t due_q[$];
    longint atan_tab[24] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

    function new();
      view_range = VIEW_RANGE_RESET;
      radius = RADIUS_RESET;
      org_x = 0; org_y = 0; dir_x = 0; dir_y = 0; nearest = 0; slot = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_VIEW_RANGE) view_range = data;
      else if (idx == CFG_OBSTACLE_RADIUS) radius = data[15:0];
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint clamp(longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
    endfunction

    function longint root_floor(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return longint'(root);
    endfunction

    // CORDIC rotation to a unit direction
    function void aim(logic signed [15:0] ang);
      longint a, x, y, z, xs, ys;
      bit flip;
      a = longint'(ang) * 16;
      x = GAIN_Q30; y = 0; flip = 0;
      if (a > PI_Q16) a -= TWO_PI_Q16;
      else if (a < -PI_Q16) a += TWO_PI_Q16;
      if (a > HALF_PI_Q16) begin a -= PI_Q16; flip = 1; end
      else if (a < -HALF_PI_Q16) begin a += PI_Q16; flip = 1; end
      z = a;
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin x -= ys; y += xs; z -= atan_tab[i]; end
        else begin x += ys; y -= xs; z += atan_tab[i]; end
      end
      x = clamp((x + 8192) >>> 14);
      y = clamp((y + 8192) >>> 14);
      dir_x = flip ? -x : x;
      dir_y = flip ? -y : y;
    endfunction

    function void circle(longint cx, longint cy);
      longint wx, wy, p24, p8, e8, act;
      wx = cx - org_x; wy = cy - org_y;
      p24 = dir_x * wx + dir_y * wy;
      if (p24 <= 0) return;
      p8 = p24 >>> 16;
      if (p8 >= nearest) return;
      e8 = mag(dir_x * wy - dir_y * wx) >>> 16;
      if (e8 > radius) return;
      act = p8 - root_floor(longint'(radius * radius - e8 * e8));
      if (act > 0 && act < nearest) nearest = act;
    endfunction

    function void segment(longint ax, longint ay, longint bx, longint by);
      longint vax, vay, vbx, vby, al_a, ac_a, al_b, ac_b, wa, wb, num, den, s;
      vax = ax - org_x; vay = ay - org_y;
      vbx = bx - org_x; vby = by - org_y;
      al_a = dir_x * vax + dir_y * vay;
      ac_a = dir_x * vay - dir_y * vax;
      al_b = dir_x * vbx + dir_y * vby;
      ac_b = dir_x * vby - dir_y * vbx;
      if (view_range == 0 || mag(ac_b - ac_a) <= 4294967 / view_range) return;
      if (!((ac_a >= 0 && ac_b <= 0) || (ac_a <= 0 && ac_b >= 0))) return;
      wa = mag(ac_a);
      wb = mag(ac_b);
      while (wa >= (64'sd1 << 28) || wb >= (64'sd1 << 28)) begin
        wa >>>= 1;
        wb >>>= 1;
      end
      den = wa + wb;
      if (den <= 0) return;
      num = (al_a >>> 16) * wb + (al_b >>> 16) * wa;
      if (num < 0) return;
      s = num / den;
      if (s <= view_range && s < nearest) nearest = s;
    endfunction

    // Accepted request: update the ray and queue any result it causes
    function void note_item(in_item_t it);
      out_item_t r;
      longint ratio;
      case (it.mode)
        MODE_START: begin
          org_x = it.origin_x;
          org_y = it.origin_y;
          aim(it.angle);
          slot = it.ray_slot;
          nearest = view_range;
        end
        MODE_CIRCLE:  circle(it.point_x, it.point_y);
        MODE_SEGMENT: segment(it.point_x, it.point_y, it.end_x, it.end_y);
        default: ;
      endcase
      if (!it.last || slot >= SLOTS) return;
      if (view_range == 0) ratio = 65536;
      else begin
        ratio = (nearest << 16) / view_range;
        if (ratio > 65536) ratio = 65536;
      end
      r.distance_ratio = ratio[16:0];
      r.slot_out = slot[2:0];
      due_q.push_back(r);
    endfunction

    // 0: nothing was waiting, 1: result as expected, 2: result differs
    function int check_result(out_item_t got, output out_item_t want);
      want = '0;
      if (due_q.size() == 0) return 0;
      want = due_q.pop_front();
      return (got == want) ? 1 : 2;
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic clk, rst, push, full, empty, pop, cfg_valid, cfg_ready;
  in_item_t item;
  out_item_t result;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hit_scoreboard sb = new();
  int errors = 0, n_items = 0, n_results = 0, n_hits = 0;
  longint cycles = 0;
  bit calm = 0;
  int pop_stall = 0;

  ray_nearest_hit_caster dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  task automatic report(string what, out_item_t got, out_item_t want);
    errors++;
    $display("MISMATCH %0s: ratio %0d slot %0d, wanted ratio %0d slot %0d",
             what, got.distance_ratio, got.slot_out, want.distance_ratio, want.slot_out);
  endtask

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: check accepted results, pop with random stall bursts
  always @(posedge clk) begin
    out_item_t want;
    int status;
    if (!rst && pop && !empty) begin
      n_results++;
      status = sb.check_result(result, want);
      if (status == 0) report("unexpected result", result, want);
      else begin
        if (status == 2) begin
          if (result.distance_ratio != want.distance_ratio) report("distance_ratio", result, want);
          if (result.slot_out != want.slot_out) report("slot_out", result, want);
        end
        if (want.distance_ratio != RATIO_MAX) n_hits++;
      end
    end
    if (rst) pop <= 1'b0;
    else if (pop_stall > 0) begin
      pop_stall--;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(9) == 0) begin
      pop_stall = $urandom_range(17);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic send(in_item_t it);
    if (!calm && $urandom_range(7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(it);
    n_items++;
  endtask

  // Sender pause: wait for every result, then let a silent item finish
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t noise();
    logic [255:0] raw;
    in_item_t it;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic logic signed [31:0] near_to(logic signed [31:0] c, int span);
    return c + $signed($urandom_range(2 * span)) - span;
  endfunction

  function automatic in_item_t obstacle(bit is_seg, logic signed [31:0] ox,
                                        logic signed [31:0] oy, int span, bit fin);
    in_item_t it;
    it = noise();
    it.mode = is_seg ? MODE_SEGMENT : MODE_CIRCLE;
    it.point_x = near_to(ox, span);
    it.point_y = near_to(oy, span);
    it.end_x = near_to(ox, span);
    it.end_y = near_to(oy, span);
    it.last = fin;
    return it;
  endfunction

  // One well-formed ray: start, a few obstacles, last on the final one
  task automatic cast_ray();
    in_item_t st;
    int n, span;
    st = noise();
    st.mode = MODE_START;
    st.last = 0;
    if ($urandom_range(3) != 0) begin
      st.origin_x = $signed($urandom_range(1 << 22)) - (1 << 21);
      st.origin_y = $signed($urandom_range(1 << 22)) - (1 << 21);
    end
    span = sb.view_range > (1 << 24) / 2 ? (1 << 24) : int'(sb.view_range) * 5 / 4 + 8;
    n = $urandom_range(1, 6);
    send(st);
    for (int i = 0; i < n; i++)
      send(obstacle(1'($urandom_range(1)), st.origin_x, st.origin_y, span, i == n - 1));
  endtask

  task automatic random_phase(int rays);
    in_item_t it;
    for (int i = 0; i < rays; i++) begin
      if ($urandom_range(9) < 8) cast_ray();
      else begin
        it = noise();
        if ($urandom_range(3) == 0) it.mode = MODE_START;
        send(it);
      end
    end
  endtask

  initial begin
    in_item_t it;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: obstacles before any start, with the reset ray state
    it = '0; it.mode = MODE_CIRCLE; it.point_x = 32'sd1000; it.last = 1; send(it);
    it = '0; it.mode = MODE_SEGMENT; it.point_x = 32'sd500; it.point_y = -32'sd500;
    it.end_x = 32'sd500; it.end_y = 32'sd500; it.last = 1; send(it);
    // Start with last, angle extremes
    it = '0; it.mode = MODE_START; it.angle = 16'sh7fff; it.ray_slot = 3'd7;
    it.last = 1; send(it);
    it.angle = 16'sh8000; it.ray_slot = 3'd0; send(it);
    it.angle = 16'sd6434; send(it);
    it.angle = -16'sd6434; send(it);
    // Ray along +x: circle dead ahead, segment across, no-obstacle item, repeated last
    it = '0; it.mode = MODE_START; it.ray_slot = 3'd5; send(it);
    it = '0; it.mode = MODE_CIRCLE; it.point_x = 32'sd12800; send(it);
    it = '0; it.mode = MODE_SEGMENT; it.point_x = 32'sd5120; it.point_y = -32'sd2560;
    it.end_x = 32'sd5120; it.end_y = 32'sd2560; it.last = 1; send(it);
    it = '0; it.mode = CMD_NONE; it.last = 1; send(it);
    it.last = 1; send(it);
    // Coordinate extremes against an extreme origin
    it = '0; it.mode = MODE_START; it.origin_x = 32'sh80000000; it.origin_y = 32'sh7fffffff;
    it.angle = 16'sd3217; send(it);
    it = '0; it.mode = MODE_CIRCLE; it.point_x = 32'sh7fffffff; it.point_y = 32'sh80000000;
    send(it);
    it = '0; it.mode = MODE_SEGMENT; it.point_x = 32'sh7fffffff; it.point_y = 32'sh7fffffff;
    it.end_x = 32'sh80000000; it.end_y = 32'sh80000000; it.last = 1; send(it);
    // Parallel segment, rejected
    it = '0; it.mode = MODE_START; send(it);
    it = '0; it.mode = MODE_SEGMENT; it.point_x = 32'sd100; it.point_y = 32'sd50;
    it.end_x = 32'sd9000; it.end_y = 32'sd50; it.last = 1; send(it);
    // Register write in the middle of a ray
    it = '0; it.mode = MODE_START; it.ray_slot = 3'd2; send(it);
    drain();
    write_reg(CFG_OBSTACLE_RADIUS, 24'd65535);
    write_reg(CFG_VIEW_RANGE, 24'd1000);
    it = '0; it.mode = MODE_CIRCLE; it.point_x = 32'sd20000; it.last = 1; send(it);

    // Random phases across register settings, extremes among them
    drain(); write_reg(CFG_VIEW_RANGE, 24'd38400); write_reg(CFG_OBSTACLE_RADIUS, 24'd4096);
    random_phase(50);
    drain(); write_reg(CFG_VIEW_RANGE, 24'd1); write_reg(CFG_OBSTACLE_RADIUS, 24'd1);
    random_phase(25);
    drain(); write_reg(CFG_VIEW_RANGE, 24'hffffff); write_reg(CFG_OBSTACLE_RADIUS, 24'd65535);
    random_phase(25);
    for (int p = 0; p < 3; p++) begin
      drain();
      write_reg(CFG_VIEW_RANGE, 24'($urandom_range(1, 200000)));
      write_reg(CFG_OBSTACLE_RADIUS, 24'($urandom_range(1, 65535)));
      random_phase(25);
    end
    drain(); write_reg(CFG_VIEW_RANGE, 24'd38400); write_reg(CFG_OBSTACLE_RADIUS, 24'd8192);
    random_phase(25);
    // Closing stretch with no idling on either side
    calm = 1;
    random_phase(20);

    drain();
    $display("covered %0d requests and %0d results (%0d with a hit) over 9 register settings",
             n_items, n_results, n_hits);
    if (errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never seen", errors, sb.pending());
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ----- files.f -----
sv/rnh_pkg.sv
sv/rnh_queue.sv
sv/rnh_front.sv
sv/rnh_iter.sv
sv/rnh_back.sv
sv/ray_nearest_hit_caster.sv
tb/sv/ray_nearest_hit_caster_test.sv
